// File: rtl/sacl_pkg.sv
// Shared types and constants for the set-associative LRU write-back cache.
package sacl_pkg;

  localparam int MaxSets    = 64;
  localparam int MaxWays    = 4;
  localparam int AddrWidth  = 32;
  localparam int SetBits    = $clog2(MaxSets);
  localparam int WayBits    = 2;
  localparam int TagWidth   = 30;
  localparam int RankWidth  = 2;
  localparam int QueueDepth = 2;

  localparam logic [1:0] RegOffsetBits = 2'd0;
  localparam logic [1:0] RegIndexBits  = 2'd1;
  localparam logic [1:0] RegWaysInUse  = 2'd2;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // classified access handed from the front to the back
  typedef struct packed {
    logic                  is_write;
    logic [SetBits-1:0]    set_index;
    logic [TagWidth-1:0]   tag;
    logic [2:0]            ways;
  } access_t;

  // one set's worth of state
  typedef struct packed {
    logic [MaxWays-1:0][TagWidth-1:0]  tags;
    logic [MaxWays-1:0]                valid;
    logic [MaxWays-1:0]                dirty;
    logic [MaxWays-1:0][RankWidth-1:0] rank;
  } set_line_t;

  typedef struct packed {
    logic               hit;
    logic               wrote_back;
    logic [WayBits-1:0] way_used;
  } outcome_t;

endpackage

// File: rtl/sacl_front.sv
// Front end: clamps the geometry, splits the address and queues the access.
module sacl_front
  import sacl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode,
  input  logic [AddrWidth-1:0] address,
  input  logic [3:0]           offset_bits,
  input  logic [2:0]           index_bits,
  input  logic [2:0]           ways_in_use,
  output logic                 q_valid,
  output access_t              q_head,
  input  logic                 q_take
);

  access_t             entries [QueueDepth];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic [3:0]          ob;
  logic [2:0]          ib;
  logic [2:0]          ways;
  logic [AddrWidth-1:0] shifted;
  logic [AddrWidth-1:0] tag_full;
  access_t             incoming;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    ob = offset_bits;
    if (offset_bits < 4'd2) ob = 4'd2;
    if (offset_bits > 4'd8) ob = 4'd8;
    ib = (index_bits > 3'(SetBits)) ? 3'(SetBits) : index_bits;
    ways = ways_in_use;
    if (ways_in_use == 3'd0) ways = 3'd1;
    if (ways_in_use > 3'(MaxWays)) ways = 3'(MaxWays);
    shifted  = address >> ob;
    tag_full = shifted >> ib;
    incoming.is_write  = (opcode == OpWrite);
    incoming.set_index = shifted[SetBits-1:0] & SetBits'((7'd1 << ib) - 7'd1);
    incoming.tag       = tag_full[TagWidth-1:0];
    incoming.ways      = ways;
  end

  assign full    = (count == 2'(QueueDepth));
  assign q_valid = (count != 2'd0);
  assign q_head  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QueueDepth)) else $error("queue count overflow");
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    full && !do_pop |=> count == 2'(QueueDepth)) else $error("full lost entry");
  a_empty_take: assert property (@(posedge clk) disable iff (rst)
    !q_valid && !do_push |=> !q_valid) else $error("queue invented entry");
`endif

endmodule

// File: rtl/sacl_back.sv
// Back end: set lookup, LRU replacement, line update and running totals.
module sacl_back
  import sacl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  access_t     q_head,
  output logic        q_take,
  input  logic        pop,
  output logic        empty,
  output logic        hit,
  output logic        wrote_back,
  output logic [1:0]  way_used,
  output logic [31:0] read_count,
  output logic [31:0] write_count,
  output logic [31:0] writeback_count,
  output logic [31:0] read_hit_count,
  output logic [31:0] write_hit_count
);

  typedef enum logic [1:0] {
    ST_FETCH  = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  localparam int LineWidth = $bits(set_line_t);

  logic [LineWidth-1:0] set_mem [MaxSets];
  logic [MaxSets-1:0]   set_used;
  state_t               state;
  access_t              cur;
  logic [LineWidth-1:0] rd_data;
  logic                 rd_used;
  set_line_t            line;
  set_line_t            line_next;
  outcome_t             oc;
  logic                 res_valid;
  logic                 can_issue;
  logic [MaxWays-1:0]   in_use;
  logic [MaxWays-1:0]   match;
  logic [RankWidth:0]   old_rank;
  logic                 found_free;
  logic [WayBits-1:0]   w;
  logic                 was_valid;

  assign can_issue = !res_valid || pop;
  assign q_take    = (state == ST_FETCH) && q_valid && can_issue;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    rd_data <= set_mem[q_head.set_index];
    rd_used <= set_used[q_head.set_index];
    if (q_take) cur <= q_head;
    if (state == ST_UPDATE) set_mem[cur.set_index] <= line_next;
  end

  always_comb begin
    line = rd_used ? set_line_t'(rd_data) : '0;
    for (int k = 0; k < MaxWays; k++) begin
      in_use[k] = (3'(k) < cur.ways);
      match[k]  = in_use[k] && line.valid[k] && (line.tags[k] == cur.tag);
    end
    oc = '0;
    w = '0;
    for (int k = MaxWays - 1; k >= 0; k--) begin
      if (match[k]) w = WayBits'(k);
    end
    oc.hit = |match;
    found_free = 1'b0;
    if (!oc.hit) begin
      for (int k = MaxWays - 1; k >= 0; k--) begin
        if (in_use[k] && !line.valid[k]) begin
          w = WayBits'(k);
          found_free = 1'b1;
        end
      end
      if (!found_free) begin
        w = '0;
        for (int k = 1; k < MaxWays; k++) begin
          if (in_use[k] && line.rank[k] > line.rank[w]) w = WayBits'(k);
        end
      end
    end
    was_valid = line.valid[w];
    oc.wrote_back = !oc.hit && was_valid && line.dirty[w];
    oc.way_used = w;
    old_rank = was_valid ? {1'b0, line.rank[w]} : 3'(MaxWays);
    line_next = line;
    for (int k = 0; k < MaxWays; k++) begin
      if (in_use[k] && WayBits'(k) != w && line.valid[k] &&
          {1'b0, line.rank[k]} < old_rank && line.rank[k] < RankWidth'(MaxWays - 1))
        line_next.rank[k] = line.rank[k] + 2'd1;
    end
    line_next.rank[w] = '0;
    if (!oc.hit) begin
      line_next.tags[w]  = cur.tag;
      line_next.valid[w] = 1'b1;
      line_next.dirty[w] = 1'b0;
    end
    if (cur.is_write) line_next.dirty[w] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_FETCH;
      set_used        <= '0;
      res_valid       <= 1'b0;
      read_count      <= '0;
      write_count     <= '0;
      writeback_count <= '0;
      read_hit_count  <= '0;
      write_hit_count <= '0;
    end else begin
      if (res_valid && pop) res_valid <= 1'b0;
      case (state)
        ST_FETCH: begin
          if (q_take) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_FETCH;
          set_used[cur.set_index] <= 1'b1;
          res_valid  <= 1'b1;
          hit        <= oc.hit;
          wrote_back <= oc.wrote_back;
          way_used   <= oc.way_used;
          if (cur.is_write) write_count <= write_count + 32'd1;
          else read_count <= read_count + 32'd1;
          if (oc.wrote_back) writeback_count <= writeback_count + 32'd1;
          if (oc.hit && cur.is_write) write_hit_count <= write_hit_count + 32'd1;
          if (oc.hit && !cur.is_write) read_hit_count <= read_hit_count + 32'd1;
        end
        default: state <= ST_FETCH;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> !res_valid || $past(pop)) else $error("result overrun");
  a_update_follows: assert property (@(posedge clk) disable iff (rst)
    q_take |=> state == ST_UPDATE) else $error("missing update");
  a_wb_not_hit: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(hit && wrote_back)) else $error("write-back on hit");
`endif

endmodule

// File: rtl/set_assoc_cache_lru_writeback.sv
// Top level: set-associative LRU write-back cache tag model with APB config.
//
// Usage:
//   Accesses enter as words on a queue-style port: opcode (0 read, 1 write)
//   and a 32-bit byte address, taken when push is high and full is low.
//   Results leave on a queue-style port: while empty is low the oldest
//   result (hit, wrote_back, way_used and five running totals) is shown and
//   is taken when pop is high.
//   A two-entry queue decouples address classification from the set update.
//   Each access passes through the back end as one registered read of
//   the set's tags, valid, dirty and ranks, then one write of the updated
//   set. The back end takes no new access from the queue until the write
//   of the current one is done.
//   When pop stays low the finished result holds, the back end takes no
//   new access from the queue, the queue fills and full rises.
//   Reset clears all lines to invalid (one used flag per set), the totals,
//   and restores offset_bits=4, index_bits=6, ways_in_use=4. No clearing
//   pass is needed. Config writes go over APB, registers at 0x0, 0x4, 0x8.
module set_assoc_cache_lru_writeback
  import sacl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] address,
  output logic        empty,
  input  logic        pop,
  output logic        hit,
  output logic        wrote_back,
  output logic [1:0]  way_used,
  output logic [31:0] read_count,
  output logic [31:0] write_count,
  output logic [31:0] writeback_count,
  output logic [31:0] read_hit_count,
  output logic [31:0] write_hit_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] offset_bits;
  logic [2:0] index_bits;
  logic [2:0] ways_in_use;
  logic       q_valid;
  access_t    q_head;
  logic       q_take;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register file; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd4;
      index_bits  <= 3'd6;
      ways_in_use <= 3'd4;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegOffsetBits: offset_bits <= pwdata[3:0];
        RegIndexBits:  index_bits  <= pwdata[2:0];
        RegWaysInUse:  ways_in_use <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegOffsetBits: prdata = {28'd0, offset_bits};
      RegIndexBits:  prdata = {29'd0, index_bits};
      RegWaysInUse:  prdata = {29'd0, ways_in_use};
      default:       prdata = '0;
    endcase
  end

  sacl_front u_front (
    .clk, .rst, .push, .full, .opcode, .address,
    .offset_bits, .index_bits, .ways_in_use,
    .q_valid, .q_head, .q_take
  );

  sacl_back u_back (
    .clk, .rst, .q_valid, .q_head, .q_take, .pop, .empty,
    .hit, .wrote_back, .way_used, .read_count, .write_count,
    .writeback_count, .read_hit_count, .write_hit_count
  );

endmodule

// File: tb/set_assoc_cache_lru_writeback_test.sv
// Testbench for the set-associative LRU write-back cache: directed plus random accesses.
`timescale 1ns / 100ps

module set_assoc_cache_lru_writeback_test
  import sacl_pkg::*;
();

  // one access word as queued for the driver
  typedef struct {
    logic        op;
    logic [31:0] addr;
  } access_word_t;

  // one predicted result word
  typedef struct {
    logic        hit;
    logic        wb;
    logic [1:0]  way;
    logic [31:0] rd_cnt;
    logic [31:0] wr_cnt;
    logic [31:0] wb_cnt;
    logic [31:0] rd_hit_cnt;
    logic [31:0] wr_hit_cnt;
  } cache_result_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        opcode;
  logic [31:0] address;
  logic        empty;
  logic        pop;
  logic        hit;
  logic        wrote_back;
  logic [1:0]  way_used;
  logic [31:0] read_count;
  logic [31:0] write_count;
  logic [31:0] writeback_count;
  logic [31:0] read_hit_count;
  logic [31:0] write_hit_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_lru_writeback u_dut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the cache state used by the predictor
  // ---------------------------------------------------------------------------
  logic [TagWidth-1:0]  shadow_tag   [MaxSets][MaxWays];
  logic                 shadow_valid [MaxSets][MaxWays];
  logic                 shadow_dirty [MaxSets][MaxWays];
  logic [RankWidth-1:0] shadow_rank  [MaxSets][MaxWays];
  logic [31:0] tot_rd, tot_wr, tot_wb, tot_rd_hit, tot_wr_hit;
  logic [3:0]  cfg_offset;
  logic [2:0]  cfg_index;
  logic [2:0]  cfg_ways;

  access_word_t  pending_words[$];
  cache_result_t expected_results[$];

  int errors;
  int idle_cycles;
  int words_sent;
  int results_seen;
  int hits_seen;
  int writebacks_seen;
  bit sender_hold;
  bit tx_accepted;   // set at the rising edge that took the driven word
  bit rx_accepted;   // set at the rising edge that took a result word
  int rx_hold_req;   // long receiver hold-off, in cycles

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
             results_seen);
  endtask

  function automatic void clear_shadow();
    for (int s = 0; s < MaxSets; s++)
      for (int w = 0; w < MaxWays; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_dirty[s][w] = 1'b0;
        shadow_rank[s][w]  = '0;
        shadow_tag[s][w]   = '0;
      end
    tot_rd = 0; tot_wr = 0; tot_wb = 0; tot_rd_hit = 0; tot_wr_hit = 0;
    cfg_offset = 4'd4;
    cfg_index  = 3'd6;
    cfg_ways   = 3'd4;
  endfunction

  // age every valid way younger than the touched one, then make it newest
  function automatic void promote_way(int s, int nways, int w, bit was_valid);
    int old_rank;
    old_rank = was_valid ? int'(shadow_rank[s][w]) : MaxWays;
    for (int k = 0; k < nways; k++) begin
      if (k == w || !shadow_valid[s][k]) continue;
      if (int'(shadow_rank[s][k]) < old_rank && int'(shadow_rank[s][k]) < MaxWays - 1)
        shadow_rank[s][k] = shadow_rank[s][k] + 1'b1;
    end
    shadow_rank[s][w] = '0;
  endfunction

  function automatic cache_result_t predict_access(access_word_t a);
    cache_result_t r;
    int ob, ib, nways, s, w;
    logic [31:0] tag32;
    bit found, was_valid;
    ob = cfg_offset; ib = cfg_index; nways = cfg_ways;
    if (ob < 2) ob = 2;
    if (ob > 8) ob = 8;
    if (ib > SetBits) ib = SetBits;
    if (nways < 1) nways = 1;
    if (nways > MaxWays) nways = MaxWays;
    s = int'((a.addr >> ob) & ((32'd1 << ib) - 1));
    tag32 = a.addr >> (ob + ib);
    r.hit = 1'b0; r.wb = 1'b0; w = 0;
    for (int k = 0; k < nways; k++)
      if (shadow_valid[s][k] && {2'b00, shadow_tag[s][k]} == tag32) begin
        r.hit = 1'b1; w = k; break;
      end
    if (a.op == OpWrite) tot_wr++; else tot_rd++;
    if (r.hit) begin
      if (a.op == OpWrite) tot_wr_hit++; else tot_rd_hit++;
      promote_way(s, nways, w, 1'b1);
    end else begin
      found = 1'b0;
      for (int k = 0; k < nways; k++)
        if (!shadow_valid[s][k]) begin w = k; found = 1'b1; break; end
      if (!found) begin
        w = 0;
        for (int k = 1; k < nways; k++)
          if (shadow_rank[s][k] > shadow_rank[s][w]) w = k;
      end
      was_valid = shadow_valid[s][w];
      if (was_valid && shadow_dirty[s][w]) begin
        r.wb = 1'b1; tot_wb++;
      end
      shadow_tag[s][w]   = tag32[TagWidth-1:0];
      shadow_valid[s][w] = 1'b1;
      shadow_dirty[s][w] = 1'b0;
      promote_way(s, nways, w, was_valid);
    end
    if (a.op == OpWrite) shadow_dirty[s][w] = 1'b1;
    r.way = w[1:0];
    r.rd_cnt = tot_rd; r.wr_cnt = tot_wr; r.wb_cnt = tot_wb;
    r.rd_hit_cnt = tot_rd_hit; r.wr_hit_cnt = tot_wr_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word at a time from pending_words, random gap before each
  // ---------------------------------------------------------------------------
  int tx_gap;
  bit tx_loaded;
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_gap = 0;
      tx_loaded = 1'b0;
    end else begin
      // accepted at the last rising edge?
      if (tx_accepted) begin
        tx_accepted = 1'b0;
        pending_words.pop_front();
        tx_loaded = 1'b0;
      end
      if (!tx_loaded && pending_words.size() > 0 && !sender_hold) begin
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) tx_gap = 0;
        tx_loaded = 1'b1;
      end
      if (tx_loaded && tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (tx_loaded) begin
        push    <= 1'b1;
        opcode  <= pending_words[0].op;
        address <= pending_words[0].addr;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the shadow tracks the block's order
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      expected_results.push_back(predict_access('{op: opcode, addr: address}));
      words_sent++;
      tx_accepted = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int rx_gap;
  int rx_long;
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_gap = 0;
      rx_long = 0;
    end else begin
      if (rx_hold_req > 0) begin
        rx_long = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_accepted) begin
        rx_accepted = 1'b0;
        rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      end
      if (rx_long > 0) begin
        rx_long--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor / checker
  always @(posedge clk) begin
    cache_result_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (pop && !empty) begin
        rx_accepted = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 32'd1, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
          if (wrote_back !== e.wb) report_mismatch("wrote_back", wrote_back, e.wb);
          if (way_used !== e.way) report_mismatch("way_used", way_used, e.way);
          if (read_count !== e.rd_cnt) report_mismatch("read_count", read_count, e.rd_cnt);
          if (write_count !== e.wr_cnt)
            report_mismatch("write_count", write_count, e.wr_cnt);
          if (writeback_count !== e.wb_cnt)
            report_mismatch("writeback_count", writeback_count, e.wb_cnt);
          if (read_hit_count !== e.rd_hit_cnt)
            report_mismatch("read_hit_count", read_hit_count, e.rd_hit_cnt);
          if (write_hit_count !== e.wr_hit_cnt)
            report_mismatch("write_hit_count", write_hit_count, e.wr_hit_cnt);
          hits_seen += e.hit;
          writebacks_seen += e.wb;
        end
        results_seen++;
      end
      // watchdog: cycles with no accepted word on either side
      if ((pop && !empty) || (push && !full)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // APB register access, driven on falling edges
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (reg_idx)
      RegOffsetBits: cfg_offset = value[3:0];
      RegIndexBits:  cfg_index  = value[2:0];
      RegWaysInUse:  cfg_ways   = value[2:0];
      default: ;
    endcase
  endtask

  // every result in, then the back end is left to settle
  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] ob, input logic [2:0] ib,
                              input logic [2:0] nw);
    wait_drained();
    apb_write(RegOffsetBits, {28'd0, ob});
    apb_write(RegIndexBits, {29'd0, ib});
    apb_write(RegWaysInUse, {29'd0, nw});
  endtask

  function automatic void queue_access(logic op, logic [31:0] addr);
    pending_words.push_back('{op: op, addr: addr});
  endfunction

  // Mostly accesses to a small pool of tags so lines hit, get evicted and
  // go dirty; some fully random addresses as noise.
  task automatic queue_random(int n, logic [3:0] ob, logic [2:0] ib);
    int eob, eib, ntags;
    logic [31:0] a;
    eob = (ob < 2) ? 2 : (ob > 8 ? 8 : ob);
    eib = (ib > SetBits) ? SetBits : ib;
    ntags = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom;
      else begin
        a = ($urandom_range(0, ntags - 1) << (eob + eib)) |
            ($urandom_range(0, 3) << eob) | ($urandom & ((32'd1 << eob) - 1));
        if ($urandom_range(0, 7) == 0) a = a | (32'hFFFF_FFFF << (eob + eib));
      end
      queue_access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    logic [3:0] ob;
    logic [2:0] ib, nw;
    rst = 1'b1;
    push = 1'b0; pop = 1'b0; opcode = 1'b0; address = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; words_sent = 0; results_seen = 0; hits_seen = 0;
    writebacks_seen = 0; sender_hold = 1'b0; rx_hold_req = 0;
    tx_accepted = 1'b0; rx_accepted = 1'b0;
    clear_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset geometry: address extremes, read/write miss, hits,
    // dirty eviction through five tags in one set (4 ways)
    queue_access(OpRead, 32'h0000_0000);
    queue_access(OpWrite, 32'hFFFF_FFFF);
    queue_access(OpRead, 32'hFFFF_FFF0);
    queue_access(OpWrite, 32'h0000_0004);
    for (int t = 1; t <= 5; t++) queue_access(OpWrite, t << 10);
    queue_access(OpRead, 32'h0000_0000);
    queue_access(OpRead, 32'h0000_0400);
    queue_access(OpWrite, 32'hAAAA_AAAA);
    queue_access(OpWrite, 32'h5555_5555);
    wait_drained();

    // out-of-range registers: offset 0 and 15, index 7, ways 0 and 7
    set_geometry(4'd0, 3'd7, 3'd0);
    for (int t = 0; t < 4; t++) queue_access(t[0], t << 8);
    queue_access(OpRead, 32'h0000_0000);
    set_geometry(4'd15, 3'd0, 3'd7);
    for (int t = 0; t < 6; t++) queue_access(OpWrite, t << 8);
    queue_access(OpRead, 32'h0000_0100);

    // random phases through varied geometries, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin ob = 4'd2; ib = 3'd0; nw = 3'd1; end
        1: begin ob = 4'd8; ib = 3'd6; nw = 3'd4; end
        2: begin ob = 4'd2; ib = 3'd6; nw = 3'd4; end
        default: begin
          ob = $urandom_range(0, 15); ib = $urandom_range(0, 7); nw = $urandom_range(0, 7);
        end
      endcase
      set_geometry(ob, ib, nw);
      queue_random(150, ob, ib);
      if (ph == 4) begin
        // receiver holds off while the sender keeps offering: input stalls
        rx_hold_req = 60;
      end
      if (ph == 7) begin
        // sender pauses until every result is back, then resumes
        while (pending_words.size() > 75) @(posedge clk);
        sender_hold = 1'b1;
        while (expected_results.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
    end
    // a short final phase on the last geometry
    queue_random(20, cfg_offset, cfg_index);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d accesses over 15 register settings: %0d hits, %0d write-backs.",
             words_sent, hits_seen, writebacks_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: set_assoc_cache_lru_writeback.f
rtl/sacl_pkg.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_writeback.sv
tb/set_assoc_cache_lru_writeback_test.sv
